@@ sv/kvt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes of the key/value table.
// Used by the top level; no dependencies.
package kvt_pkg;

  localparam int unsigned FieldBits = 64;

  typedef enum logic [1:0] {
    OpSet = 2'd0,
    OpGet = 2'd1,
    OpDel = 2'd2,
    OpBad = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StFound    = 3'd1,
    StNotFound = 3'd2,
    StError    = 3'd3,
    StFull     = 3'd4
  } status_e;

endpackage

@@ sv/key_value_table_set_get_delete.sv @@
`timescale 1ns / 1ps
// Top level of the associative key/value table with set, get and delete.
// Depends on kvt_pkg and kvt_ram.
//
// A request beat is taken at every clock edge where start is high; busy stays low, so one
// request can enter in every cycle. Its result appears on done_o, status_o and read_value_o
// after passing the request and result registers, and is held for exactly one cycle, since the
// receiver cannot stall. The keys sit in flip-flops with one comparator per slot, and a
// priority encoder over the match and valid bits picks the slot, so each request sees the table
// as left by the one before it. Values live in a RAM whose registered read supplies the data
// in the result cycle. The valid bits clear at reset and no clearing pass is needed.
module key_value_table_set_get_delete #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op_i,
  input  logic [kvt_pkg::FieldBits-1:0] key_i,
  input  logic [kvt_pkg::FieldBits-1:0] new_value_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [kvt_pkg::FieldBits-1:0] read_value_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  logic                    req_vld_q;
  kvt_pkg::op_e            op_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [VALUE_BITS-1:0]   val_q;

  logic [ENTRIES-1:0]      slot_valid_q, slot_valid_d;
  logic [KEY_BITS-1:0]     slot_key_q [ENTRIES];

  logic [ENTRIES-1:0]      hit;
  logic                    hit_any, free_any;
  logic [IdxW-1:0]         hit_idx, free_idx;

  logic                    key_we;
  logic                    val_we;
  logic [IdxW-1:0]         val_waddr;
  logic [VALUE_BITS-1:0]   val_rdata;

  logic                    done_q, done_d;
  kvt_pkg::status_e        status_q, status_d;
  logic                    found_q, found_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      op_q  <= kvt_pkg::op_e'(op_i);
      key_q <= key_i[KEY_BITS-1:0];
      val_q <= new_value_i[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = slot_valid_q[i] && (slot_key_q[i] == key_q);
    end
  end

  always_comb begin
    hit_any  = |hit;
    free_any = ~&slot_valid_q;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IdxW'(i);
      end
      if (!slot_valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    slot_valid_d = slot_valid_q;
    key_we       = 1'b0;
    val_we       = 1'b0;
    val_waddr    = hit_any ? hit_idx : free_idx;
    done_d       = req_vld_q;
    status_d     = kvt_pkg::StError;
    found_d      = 1'b0;
    if (req_vld_q) begin
      case (op_q)
        kvt_pkg::OpSet: begin
          if (hit_any) begin
            val_we   = 1'b1;
            status_d = kvt_pkg::StOk;
          end else if (free_any) begin
            key_we                 = 1'b1;
            val_we                 = 1'b1;
            slot_valid_d[free_idx] = 1'b1;
            status_d               = kvt_pkg::StOk;
          end else begin
            status_d = kvt_pkg::StFull;
          end
        end
        kvt_pkg::OpGet: begin
          found_d  = hit_any;
          status_d = hit_any ? kvt_pkg::StFound : kvt_pkg::StNotFound;
        end
        kvt_pkg::OpDel: begin
          if (hit_any) begin
            slot_valid_d[hit_idx] = 1'b0;
          end
          status_d = kvt_pkg::StOk;
        end
        default: begin
          status_d = kvt_pkg::StError;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      done_q       <= 1'b0;
      status_q     <= kvt_pkg::StOk;
      found_q      <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
      done_q       <= done_d;
      status_q     <= status_d;
      found_q      <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      slot_key_q[free_idx] <= key_q;
    end
  end

  kvt_ram #(
    .Width(VALUE_BITS),
    .Depth(ENTRIES)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_q),
    .raddr_i(hit_idx),
    .rdata_o(val_rdata)
  );

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = found_q ? kvt_pkg::FieldBits'(val_rdata) : '0;

endmodule

@@ sv/kvt_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module kvt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
